// ----- rtl/mrdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdr_pkg: shared types and constants of the digit reversal core
// Word layout handed from cell to cell, field widths and register codes.
// ----------------------------------------------------------------------------
package mrdr_pkg;

	localparam int POS_W      = 16;
	localparam int RADIX_W    = 8;
	localparam int COUNT_W    = 4;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 1;

	// Largest transform size; a product of radices above it is rejected.
	localparam int MAX_POINTS = 65536;
	localparam int PROD_W     = $clog2(MAX_POINTS + 1);
	localparam int PRODX_W    = PROD_W + RADIX_W;
	localparam int ACCX_W     = POS_W + RADIX_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX_COUNT = 1'b0,
		REG_RADIX_LIST  = 1'b1
	} cfg_reg_t;

	// rem: partial remainder of the running division, becomes the stage digit
	// quo: dividend shifting out at the top, quotient shifting in at the bottom
	// acc: reversed index built so far
	// prod: product of the radices folded so far, big once it passes MAX_POINTS
	typedef struct packed {
		logic [RADIX_W-1:0] rem;
		logic [POS_W-1:0]   quo;
		logic [POS_W-1:0]   acc;
		logic [PROD_W-1:0]  prod;
		logic               big;
	} payload_t;

	typedef struct packed {
		logic     valid;
		payload_t pl;
	} word_t;

endpackage

// ----- rtl/mixed_radix_digit_reversal_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_radix_digit_reversal_core: FFT input reorder address generator
// Maps each output position to its mixed-radix digit-reversed source index.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_stall  position
// rsp       out        rsp_valid / rsp_stall  source_index, out_of_range
// cfg       in         cfg_wr_en              cfg_index, cfg_data
//
// One word in and one word out per cycle, sustained while rsp_stall is low.
// Each radix stage is sixteen division-step cells, one per position bit,
// plus one fold cell, and the output register follows the last stage.
// Reset loads radix_count 1 and radix_list 2 (a single radix-2 stage) and
// empties the chain. rsp_stall on a waiting result freezes the whole chain;
// one more request word parks in the input skid register, and req_stall
// is high while that register is full.
//
// Stage i divides the running quotient by radix ri bit by bit, leaving
// digit di in the remainder; the fold cell then sets acc = acc * ri + di.
// Walking the digits from the lowest upward this builds the reversed
// index. Stages at or above radix_count pass the word through. The
// position is in range exactly when the final quotient is zero, and the
// running radix product flags transforms larger than MAX_POINTS. Users must
// write configuration only while the chain is empty; the core has no check.
// ----------------------------------------------------------------------------
module mixed_radix_digit_reversal_core #(
	parameter int MAX_STAGES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_wr_en,
	input  logic [mrdr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrdr_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [mrdr_pkg::POS_W-1:0]      position,

	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [mrdr_pkg::POS_W-1:0]      source_index,
	output logic                            out_of_range
);

	localparam int CELLS_PER_STAGE = mrdr_pkg::POS_W + 1;
	localparam int N_CELLS         = MAX_STAGES * CELLS_PER_STAGE;

	// Configuration registers
	logic [mrdr_pkg::COUNT_W-1:0]    radix_count_q;
	logic [mrdr_pkg::CFG_DATA_W-1:0] radix_list_q;

	// Per-stage radix and enable
	logic [mrdr_pkg::RADIX_W-1:0] stage_radix [MAX_STAGES];
	logic                         stage_active [MAX_STAGES];

	// Input skid register
	logic                         skid_full_q;
	logic [mrdr_pkg::POS_W-1:0]   skid_pos_q;

	// Cell chain: entry 0 feeds the first cell, entry N_CELLS is the last cell
	mrdr_pkg::word_t              chain [N_CELLS+1];
	mrdr_pkg::word_t              last_word;

	// Output register
	logic                         rsp_valid_q;
	logic [mrdr_pkg::POS_W-1:0]   source_index_q;
	logic                         out_of_range_q;
	logic                         oor_d;

	logic                         adv;

	// Advance everything unless a finished result is held
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = skid_full_q;

	// Write registers by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_count_q <= mrdr_pkg::COUNT_W'(1);
			radix_list_q  <= mrdr_pkg::CFG_DATA_W'(2);
		end else if (cfg_wr_en) begin
			case (mrdr_pkg::cfg_reg_t'(cfg_index))
				mrdr_pkg::REG_RADIX_COUNT: begin
					radix_count_q <= cfg_data[mrdr_pkg::COUNT_W-1:0];
				end
				mrdr_pkg::REG_RADIX_LIST: begin
					radix_list_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Park a word when the chain holds; drain it on the next advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (adv) begin
			skid_full_q <= 1'b0;
		end else if (req_valid && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && req_valid && !skid_full_q) begin
			skid_pos_q <= position;
		end
	end

	// Launch word: skid first, else the live request
	always_comb begin
		chain[0].valid   = skid_full_q || req_valid;
		chain[0].pl.rem  = '0;
		chain[0].pl.quo  = skid_full_q ? skid_pos_q : position;
		chain[0].pl.acc  = '0;
		chain[0].pl.prod = mrdr_pkg::PROD_W'(1);
		chain[0].pl.big  = 1'b0;
	end

	for (genvar s = 0; s < MAX_STAGES; s++) begin : g_stage
		// A zero radix byte acts as radix one
		assign stage_radix[s] =
			(radix_list_q[s*mrdr_pkg::RADIX_W +: mrdr_pkg::RADIX_W] == '0)
			? mrdr_pkg::RADIX_W'(1)
			: radix_list_q[s*mrdr_pkg::RADIX_W +: mrdr_pkg::RADIX_W];
		assign stage_active[s] = (radix_count_q > mrdr_pkg::COUNT_W'(s));

		for (genvar b = 0; b < mrdr_pkg::POS_W; b++) begin : g_bit
			mrdr_div_cell u_div (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.radix    (stage_radix[s]),
				.active   (stage_active[s]),
				.word_in  (chain[s*CELLS_PER_STAGE + b]),
				.word_out (chain[s*CELLS_PER_STAGE + b + 1])
			);
		end

		mrdr_fold_cell u_fold (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.radix    (stage_radix[s]),
			.active   (stage_active[s]),
			.word_in  (chain[s*CELLS_PER_STAGE + mrdr_pkg::POS_W]),
			.word_out (chain[(s+1)*CELLS_PER_STAGE])
		);
	end

	// Out of range: leftover quotient or an oversized transform
	assign last_word = chain[N_CELLS];
	assign oor_d     = last_word.pl.big || (last_word.pl.quo != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= last_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			source_index_q <= oor_d ? '0 : last_word.pl.acc;
			out_of_range_q <= oor_d;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign source_index = source_index_q;
	assign out_of_range = out_of_range_q;

	// An out-of-range result always carries index zero
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && out_of_range_q |-> source_index_q == '0)
		else $error("out_of_range result with nonzero source_index");

	// A request taken while the chain holds must land in the skid register
	a_skid_park: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !adv |=> skid_full_q)
		else $error("request taken during hold was not parked");

	// A parked word leaves on the next advance
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && adv |=> !skid_full_q)
		else $error("skid register did not drain on advance");

endmodule

// ----- rtl/mrdr_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdr_div_cell: one restoring division step
// Shifts one dividend bit into the remainder, subtracts the radix when it
// fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module mrdr_div_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [mrdr_pkg::RADIX_W-1:0] radix,
	input  logic                         active,
	input  mrdr_pkg::word_t              word_in,
	output mrdr_pkg::word_t              word_out
);

	logic [mrdr_pkg::RADIX_W:0] trial;
	logic [mrdr_pkg::RADIX_W:0] diff;
	logic                       fits;
	mrdr_pkg::payload_t         pl_d;
	mrdr_pkg::payload_t         pl_q;
	logic                       valid_q;

	always_comb begin
		pl_d  = word_in.pl;
		trial = {word_in.pl.rem, word_in.pl.quo[mrdr_pkg::POS_W-1]};
		diff  = trial - {1'b0, radix};
		fits  = (trial >= {1'b0, radix});
		if (active) begin
			pl_d.rem = fits ? diff[mrdr_pkg::RADIX_W-1:0] : trial[mrdr_pkg::RADIX_W-1:0];
			pl_d.quo = {word_in.pl.quo[mrdr_pkg::POS_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_q <= pl_d;
		end
	end

	assign word_out = '{valid: valid_q, pl: pl_q};

endmodule

// ----- rtl/mrdr_fold_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdr_fold_cell: close one radix stage
// Folds the stage digit into the reversed index, grows the radix product
// and clears the remainder for the next stage.
// ----------------------------------------------------------------------------
module mrdr_fold_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [mrdr_pkg::RADIX_W-1:0] radix,
	input  logic                         active,
	input  mrdr_pkg::word_t              word_in,
	output mrdr_pkg::word_t              word_out
);

	logic [mrdr_pkg::PRODX_W-1:0] prod_full;
	logic [mrdr_pkg::ACCX_W-1:0]  acc_full;
	mrdr_pkg::payload_t           pl_d;
	mrdr_pkg::payload_t           pl_q;
	logic                         valid_q;

	always_comb begin
		pl_d      = word_in.pl;
		prod_full = mrdr_pkg::PRODX_W'(word_in.pl.prod) * mrdr_pkg::PRODX_W'(radix);
		acc_full  = mrdr_pkg::ACCX_W'(word_in.pl.acc) * mrdr_pkg::ACCX_W'(radix)
			+ mrdr_pkg::ACCX_W'(word_in.pl.rem);
		if (active) begin
			pl_d.acc  = acc_full[mrdr_pkg::POS_W-1:0];
			pl_d.prod = prod_full[mrdr_pkg::PROD_W-1:0];
			pl_d.big  = word_in.pl.big
				|| (prod_full > mrdr_pkg::PRODX_W'(mrdr_pkg::MAX_POINTS));
			pl_d.rem  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_q <= pl_d;
		end
	end

	assign word_out = '{valid: valid_q, pl: pl_q};

endmodule
